@@ src/integer_to_radix_digits_macros.svh @@
// Assertion macros used by the checker file.
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ITRD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ITRD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/itrd_pkg.sv @@
`default_nettype none
package itrd_pkg;

   localparam int unsigned CHUNK_BITS = 8;
   localparam int unsigned RADIX_W    = 6;
   localparam int unsigned CHAR_W     = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

   localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'd65;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z  = 8'd90;
   localparam logic [CHAR_W-1:0] CHAR_QUESTION = 8'd63;
   localparam logic [CHAR_W-1:0] LETTER_OFFSET = 8'd55;
   localparam logic [RADIX_W-1:0] DECIMAL_TEN  = 6'd10;

   typedef enum logic [2:0] {
      STEP_LOAD,
      STEP_INIT,
      STEP_DIV,
      STEP_PUSH,
      STEP_FETCH,
      STEP_EMIT,
      STEP_DONE,
      STEP_BAD
   } step_type;

   typedef enum logic [1:0] {
      WAIT_NONE,
      WAIT_REQ,
      WAIT_OUT
   } wait_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_BAD_RADIX,
      COND_CNT_MORE,
      COND_QUOT_NZ,
      COND_STACK_MORE
   } cond_type;

   typedef struct packed {
      wait_type wait_on;
      logic     ld_item;
      logic     clr_rem;
      logic     div_step;
      logic     push;
      logic     emit_digit;
      logic     emit_bad;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic req_ready;
      logic ld_item;
      logic clr_rem;
      logic div_step;
      logic push;
      logic emit_digit;
      logic emit_bad;
   } act_type;

   typedef struct packed {
      logic req_valid;
      logic out_free;
      logic bad_radix;
      logic cnt_more;
      logic quot_nz;
      logic stack_more;
   } stat_type;

   function automatic ctrl_type microcode(input step_type step);
      ctrl_type w;
      w = '0;
      case (step)
         STEP_LOAD: begin
            w.wait_on = WAIT_REQ;
            w.ld_item = 1'b1;
            w.cond    = COND_BAD_RADIX;
            w.target  = STEP_BAD;
         end
         STEP_INIT: begin
            w.clr_rem = 1'b1;
         end
         STEP_DIV: begin
            w.div_step = 1'b1;
            w.cond     = COND_CNT_MORE;
            w.target   = STEP_DIV;
         end
         STEP_PUSH: begin
            w.push   = 1'b1;
            w.cond   = COND_QUOT_NZ;
            w.target = STEP_INIT;
         end
         STEP_FETCH: begin
            w.cond = COND_NEVER;
         end
         STEP_EMIT: begin
            w.wait_on    = WAIT_OUT;
            w.emit_digit = 1'b1;
            w.cond       = COND_STACK_MORE;
            w.target     = STEP_FETCH;
         end
         STEP_DONE: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_LOAD;
         end
         STEP_BAD: begin
            w.wait_on  = WAIT_OUT;
            w.emit_bad = 1'b1;
            w.cond     = COND_ALWAYS;
            w.target   = STEP_LOAD;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_LOAD;
         end
      endcase
      return w;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] wide;
      wide = {{(CHAR_W-RADIX_W){1'b0}}, d};
      if (d < DECIMAL_TEN) begin
         return wide + CHAR_ZERO;
      end
      return wide + LETTER_OFFSET;
   endfunction

endpackage
`default_nettype wire

@@ src/integer_to_radix_digits.sv @@
// Converts a non-negative integer to its digit text in radix 2 to 36, one ASCII character
// per transfer, most significant first, '0'-'9' then 'A'-'Z', with is_last on the final
// character; zero gives "0" and any other radix gives a single '?' marked last. One item is
// handled at a time. Each digit comes from the shared divider, which takes eight quotient
// bits per cycle over the CHUNKS = ceil(VALUE_BITS / 8) chunks of the value, and is pushed
// onto the digit stack, from which the digits are read back in reverse order. Inputs are
// taken while the last character of the previous item still waits in the output register.
`default_nettype none
module integer_to_radix_digits
   import itrd_pkg::*;
#(
   parameter int unsigned VALUE_BITS = 31
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [VALUE_BITS-1:0] req_number_value,
   input  wire logic [RADIX_W-1:0]    req_base_radix,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [CHAR_W-1:0]          rsp_digit_char,
   output logic                       rsp_is_last
);

   act_type            act;
   stat_type           stat;
   logic               cnt_more;
   logic               quot_nz;
   logic               stack_more;
   logic [RADIX_W-1:0] digit;
   logic [CHAR_W-1:0]  top_char;
   logic               rsp_valid_ff;
   logic [CHAR_W-1:0]  rsp_char_ff;
   logic               rsp_last_ff;

   always_comb begin
      stat.req_valid  = req_valid;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
      stat.bad_radix  = (req_base_radix < RADIX_MIN) || (req_base_radix > RADIX_MAX);
      stat.cnt_more   = cnt_more;
      stat.quot_nz    = quot_nz;
      stat.stack_more = stack_more;
   end

   itrd_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .act   (act)
   );

   itrd_div #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock        (clock),
      .act          (act),
      .number_value (req_number_value),
      .base_radix   (req_base_radix),
      .cnt_more     (cnt_more),
      .quot_nz      (quot_nz),
      .digit        (digit)
   );

   itrd_stack #(
      .VALUE_BITS (VALUE_BITS)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .act        (act),
      .push_char  (digit_to_char(digit)),
      .top_char   (top_char),
      .stack_more (stack_more)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (act.emit_digit || act.emit_bad) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (act.emit_bad) begin
         rsp_char_ff <= CHAR_QUESTION;
         rsp_last_ff <= 1'b1;
      end else if (act.emit_digit) begin
         rsp_char_ff <= top_char;
         rsp_last_ff <= !stack_more;
      end
   end

   assign req_ready      = act.req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_is_last    = rsp_last_ff;

endmodule
`default_nettype wire

@@ src/itrd_seq.sv @@
`default_nettype none
module itrd_seq
   import itrd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire stat_type stat,
   output act_type       act
);

   step_type step_ff;
   step_type step_in;
   ctrl_type word;
   logic     go;
   logic     taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      word = microcode(step_ff);
      case (word.wait_on)
         WAIT_NONE: go = 1'b1;
         WAIT_REQ:  go = stat.req_valid;
         WAIT_OUT:  go = stat.out_free;
         default:   go = 1'b1;
      endcase
      case (word.cond)
         COND_NEVER:      taken = 1'b0;
         COND_ALWAYS:     taken = 1'b1;
         COND_BAD_RADIX:  taken = stat.bad_radix;
         COND_CNT_MORE:   taken = stat.cnt_more;
         COND_QUOT_NZ:    taken = stat.quot_nz;
         COND_STACK_MORE: taken = stat.stack_more;
         default:         taken = 1'b0;
      endcase
      if (!go) begin
         step_in = step_ff;
      end else if (taken) begin
         step_in = word.target;
      end else begin
         step_in = step_type'(3'(step_ff) + 3'd1);
      end
      act.req_ready  = (word.wait_on == WAIT_REQ);
      act.ld_item    = word.ld_item & go;
      act.clr_rem    = word.clr_rem & go;
      act.div_step   = word.div_step & go;
      act.push       = word.push & go;
      act.emit_digit = word.emit_digit & go;
      act.emit_bad   = word.emit_bad & go;
   end

endmodule
`default_nettype wire

@@ src/itrd_div.sv @@
`default_nettype none
module itrd_div
   import itrd_pkg::*;
#(
   parameter int unsigned VALUE_BITS = 31
) (
   input  wire logic                  clock,
   input  wire act_type               act,
   input  wire logic [VALUE_BITS-1:0] number_value,
   input  wire logic [RADIX_W-1:0]    base_radix,
   output logic                       cnt_more,
   output logic                       quot_nz,
   output logic [RADIX_W-1:0]         digit
);

   localparam int unsigned CHUNKS = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int unsigned PAD_W  = CHUNKS * CHUNK_BITS;
   localparam int unsigned CNT_W  = $clog2(CHUNKS + 1);

   logic [PAD_W-1:0]            val_ff;
   logic [PAD_W-1:0]            val_in;
   logic [RADIX_W-1:0]          radix_ff;
   logic [RADIX_W-1:0]          rem_ff;
   logic [RADIX_W-1:0]          rem_in;
   logic [CNT_W-1:0]            cnt_ff;
   logic [CHUNK_BITS-1:0]       qbits;
   logic [PAD_W+CHUNK_BITS-1:0] shifted;
   logic [RADIX_W:0]            trial;
   logic [RADIX_W-1:0]          r;

   always_comb begin
      r = rem_ff;
      qbits = '0;
      trial = '0;
      for (int i = 0; i < CHUNK_BITS; i++) begin
         trial = {r, val_ff[PAD_W-1-i]};
         if (trial >= {1'b0, radix_ff}) begin
            trial = trial - {1'b0, radix_ff};
            qbits[CHUNK_BITS-1-i] = 1'b1;
         end
         r = trial[RADIX_W-1:0];
      end
      rem_in  = r;
      shifted = {val_ff, qbits};
      val_in  = shifted[PAD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (act.ld_item) begin
         val_ff   <= PAD_W'(number_value);
         radix_ff <= base_radix;
      end else if (act.div_step) begin
         val_ff <= val_in;
      end
      if (act.clr_rem) begin
         rem_ff <= '0;
         cnt_ff <= CNT_W'(CHUNKS - 1);
      end else if (act.div_step) begin
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   assign cnt_more = (cnt_ff != '0);
   assign quot_nz  = |val_ff;
   assign digit    = rem_ff;

endmodule
`default_nettype wire

@@ src/itrd_stack.sv @@
`default_nettype none
module itrd_stack
   import itrd_pkg::*;
#(
   parameter int unsigned VALUE_BITS = 31
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire act_type           act,
   input  wire logic [CHAR_W-1:0] push_char,
   output logic [CHAR_W-1:0]      top_char,
   output logic                   stack_more
);

   localparam int unsigned AW   = $clog2(VALUE_BITS);
   localparam int unsigned SP_W = $clog2(VALUE_BITS + 1);

   logic [CHAR_W-1:0] mem [VALUE_BITS];
   logic [SP_W-1:0]   sp_ff;
   logic [SP_W-1:0]   sp_dec;
   logic [CHAR_W-1:0] rd_data_ff;

   assign sp_dec = sp_ff - SP_W'(1);

   always_ff @(posedge clock) begin
      if (reset || act.ld_item) begin
         sp_ff <= '0;
      end else if (act.push) begin
         sp_ff <= sp_ff + SP_W'(1);
      end else if (act.emit_digit) begin
         sp_ff <= sp_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (act.push) begin
         mem[sp_ff[AW-1:0]] <= push_char;
      end
      rd_data_ff <= mem[sp_dec[AW-1:0]];
   end

   assign top_char   = rd_data_ff;
   assign stack_more = (sp_ff > SP_W'(1));

endmodule
`default_nettype wire

@@ src/itrd_checker.sv @@
`default_nettype none
`include "integer_to_radix_digits_macros.svh"
module itrd_checker
   import itrd_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [CHAR_W-1:0] rsp_digit_char,
   input wire logic              rsp_is_last
);

   logic legal_char;
   logic req_xfer;
   logic rsp_xfer;

   assign legal_char = ((rsp_digit_char >= CHAR_ZERO) && (rsp_digit_char <= CHAR_NINE))
                    || ((rsp_digit_char >= CHAR_UPPER_A) && (rsp_digit_char <= CHAR_UPPER_Z))
                    || (rsp_digit_char == CHAR_QUESTION);
   assign req_xfer   = req_valid && req_ready;
   assign rsp_xfer   = rsp_valid && rsp_ready;

   `ITRD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digit_char) && $stable(rsp_is_last), "Stalled result changed or dropped.")
   `ITRD_ASSERT(a_legal_char, clock, reset, rsp_valid |-> legal_char, "Result is not a digit character.")
   `ITRD_ASSERT(a_bad_is_last, clock, reset, rsp_valid && (rsp_digit_char == CHAR_QUESTION) |-> rsp_is_last, "Bad radix mark is not last.")
   `ITRD_ASSERT(a_busy_after_req, clock, reset, req_xfer |=> !req_ready, "Input taken again right after a transfer.")
   `ITRD_ASSERT(a_busy_mid_run, clock, reset, rsp_xfer && !rsp_is_last |=> !req_ready, "Input taken before the run ended.")

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (.*);
`default_nettype wire
